@@ rtl/core/pskq_pkg.sv @@
// Package for the panel switch and knob qualifier.
// Holds switch position codes, register indexes, field widths and reset values.
// No dependencies.
package pskq_pkg;

   localparam int KNOB_RAW_W = 12;
   localparam int Q15_W      = 15;
   localparam int WAIT_W     = 16;
   localparam int LONG_W     = 17;
   localparam int CSR_DATA_W = 17;
   localparam int TOTAL_W    = 32;

   typedef enum logic [1:0] {
      POS_DOWN   = 2'd0,
      POS_MIDDLE = 2'd1,
      POS_UP     = 2'd2,
      POS_UNUSED = 2'd3
   } pos_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_LONG_PRESS  = 2'd1,
      CSR_PAGE_SETTLE = 2'd2,
      CSR_PICKUP      = 2'd3
   } csr_index_type;

   localparam logic [WAIT_W-1:0] DEBOUNCE_RESET    = WAIT_W'(960);
   localparam logic [LONG_W-1:0] LONG_PRESS_RESET  = LONG_W'(96000);
   localparam logic [WAIT_W-1:0] PAGE_SETTLE_RESET = WAIT_W'(576);
   localparam logic [Q15_W-1:0]  PICKUP_RESET      = Q15_W'(1200);
   localparam logic [Q15_W-1:0]  KNOB_MID_RESET    = Q15_W'(16384);
   localparam logic [Q15_W-1:0]  KNOB_FULL_RESET   = Q15_W'(32767);

endpackage

@@ rtl/core/panel_switch_knob_qualifier_unit.sv @@
// Top level of the panel switch and knob qualifier.
// Uses pskq_pkg for position codes, register indexes, widths and reset values.
//
// Usage: one panel sample (switch position, trigger and freeze gates, three
// raw 12-bit knobs) enters on the req_ channel per tick. Each accepted request
// produces exactly one result on the rsp_ channel: freeze and sealed flags,
// the committed page, the trigger edge count, the held output level and the
// five knob slots in Q15.
// The state update and the result are computed in one pass from the request
// and the state registers and land in the result register at the accepting
// edge. Throughput is one request per cycle while the receiver does not stall;
// the single result register is the only buffer, so a request is taken
// whenever that register is empty or is being drained in the same cycle.
// When the receiver stalls with a result waiting, req_stall goes high and the
// result is held unchanged until it is taken.
// Configuration writes on the csr_ channel are always ready and take effect
// at the next request. Synchronous reset returns the configuration and all
// qualifier state to reset values and empties the result register.
module panel_switch_knob_qualifier_unit
   import pskq_pkg::*;
#(
   parameter int KNOB_COUNT       = 3,
   parameter int EDGE_COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_switch_pos,
   input  logic                  req_gate_trigger,
   input  logic                  req_gate_freeze,
   input  logic [KNOB_RAW_W-1:0] req_knob_main,
   input  logic [KNOB_RAW_W-1:0] req_knob_x,
   input  logic [KNOB_RAW_W-1:0] req_knob_y,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_freeze_on,
   output logic                  rsp_sealed_on,
   output logic                  rsp_page_now,
   output logic [TOTAL_W-1:0]    rsp_trigger_total,
   output logic [Q15_W-1:0]      rsp_out_level,
   output logic [Q15_W-1:0]      rsp_speed_param,
   output logic [Q15_W-1:0]      rsp_density_param,
   output logic [Q15_W-1:0]      rsp_source_param,
   output logic [Q15_W-1:0]      rsp_quantise_param,
   output logic [Q15_W-1:0]      rsp_width_param,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WAIT_W-1:0] debounce_ff;
   logic [LONG_W-1:0] long_press_ff;
   logic [WAIT_W-1:0] page_settle_ff;
   logic [Q15_W-1:0]  pickup_ff;

   logic [1:0]                  last_pos_ff, last_pos_in;
   logic [WAIT_W-1:0]           switch_wait_ff, switch_wait_in;
   logic [LONG_W-1:0]           down_count_ff, down_count_in;
   logic [WAIT_W-1:0]           page_wait_ff, page_wait_in;
   logic                        pending_pg_ff, pending_pg_in;
   logic                        current_pg_ff, current_pg_in;
   logic                        freeze_latch_ff, freeze_latch_in;
   logic                        sealed_latch_ff, sealed_latch_in;
   logic                        prev_trigger_ff;
   logic [EDGE_COUNT_WIDTH-1:0] edge_count_ff, edge_count_in;
   logic [1:0]                  knob_turn_ff, knob_turn_in;
   logic [Q15_W-1:0]            knob_store_ff [6];
   logic [Q15_W-1:0]            knob_store_in [6];
   logic [Q15_W-1:0]            arrival_y_ff, arrival_y_in;
   logic                        level_follows_ff, level_follows_in;
   logic [Q15_W-1:0]            level_kept_ff, level_kept_in;

   logic                        rsp_valid_ff;
   logic                        accept;

   logic [1:0]          sw;
   logic [WAIT_W-1:0]   wait_dec;
   logic [LONG_W-1:0]   down_inc;
   logic [Q15_W-1:0]    knob_val;
   logic [Q15_W-1:0]    knob_diff;
   logic [2:0]          slot_idx;
   logic [2:0]          turn_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      sw = (req_switch_pos == POS_UNUSED) ? POS_MIDDLE : req_switch_pos;
      wait_dec = (switch_wait_ff != '0) ? switch_wait_ff - 1'b1 : switch_wait_ff;

      last_pos_in      = last_pos_ff;
      switch_wait_in   = wait_dec;
      down_count_in    = down_count_ff;
      page_wait_in     = page_wait_ff;
      pending_pg_in    = pending_pg_ff;
      current_pg_in    = current_pg_ff;
      freeze_latch_in  = freeze_latch_ff;
      sealed_latch_in  = sealed_latch_ff;
      arrival_y_in     = arrival_y_ff;
      level_follows_in = level_follows_ff;
      level_kept_in    = level_kept_ff;
      for (int i = 0; i < 6; i++) begin
         knob_store_in[i] = knob_store_ff[i];
      end

      down_inc = down_count_ff + 1'b1;
      if (sw == POS_DOWN && down_count_ff < long_press_ff) begin
         down_count_in = down_inc;
         if (down_inc == long_press_ff) begin
            freeze_latch_in = 1'b1;
            sealed_latch_in = 1'b1;
         end
      end

      if (sw != last_pos_ff && wait_dec == '0) begin
         last_pos_in    = sw;
         switch_wait_in = debounce_ff;
         if (sw == POS_DOWN) begin
            down_count_in = '0;
            page_wait_in  = '0;
         end else if (last_pos_ff == POS_DOWN) begin
            if (down_count_in < long_press_ff) begin
               sealed_latch_in = 1'b0;
               freeze_latch_in = !freeze_latch_in;
            end
            down_count_in = '0;
         end else begin
            pending_pg_in = (sw == POS_UP);
            page_wait_in  = page_settle_ff;
         end
      end

      if (page_wait_in != '0) begin
         page_wait_in = page_wait_in - 1'b1;
         if (page_wait_in == '0 && pending_pg_in != current_pg_in) begin
            current_pg_in = pending_pg_in;
            if (pending_pg_in) begin
               arrival_y_in     = {req_knob_y, 3'b000};
               level_follows_in = 1'b0;
            end
         end
      end

      edge_count_in = edge_count_ff;
      if (req_gate_trigger && !prev_trigger_ff) begin
         edge_count_in = edge_count_ff + 1'b1;
      end

      case (knob_turn_ff)
         2'd0:    knob_val = {req_knob_main, 3'b000};
         2'd1:    knob_val = {req_knob_x, 3'b000};
         default: knob_val = {req_knob_y, 3'b000};
      endcase
      knob_diff = (knob_val >= arrival_y_in) ? knob_val - arrival_y_in
                                             : arrival_y_in - knob_val;
      slot_idx = current_pg_in ? 3'd3 + {1'b0, knob_turn_ff} : {1'b0, knob_turn_ff};
      if (knob_turn_ff != 2'd3) begin
         if (current_pg_in && knob_turn_ff == 2'd2 && !level_follows_in &&
             knob_diff > pickup_ff) begin
            level_follows_in = 1'b1;
         end
         knob_store_in[slot_idx] = knob_val;
      end
      turn_next = {1'b0, knob_turn_ff} + 3'd1;
      knob_turn_in = (turn_next >= 3'(KNOB_COUNT)) ? 2'd0 : turn_next[1:0];

      if (level_follows_in) begin
         level_kept_in = knob_store_in[5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
         page_settle_ff <= PAGE_SETTLE_RESET;
         pickup_ff      <= PICKUP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[WAIT_W-1:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_wdata[LONG_W-1:0];
            CSR_PAGE_SETTLE: page_settle_ff <= csr_wdata[WAIT_W-1:0];
            CSR_PICKUP:      pickup_ff      <= csr_wdata[Q15_W-1:0];
            default:         debounce_ff    <= debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff      <= POS_MIDDLE;
         switch_wait_ff   <= '0;
         down_count_ff    <= '0;
         page_wait_ff     <= '0;
         pending_pg_ff    <= 1'b0;
         current_pg_ff    <= 1'b0;
         freeze_latch_ff  <= 1'b0;
         sealed_latch_ff  <= 1'b0;
         prev_trigger_ff  <= 1'b0;
         edge_count_ff    <= '0;
         knob_turn_ff     <= 2'd0;
         knob_store_ff[0] <= KNOB_MID_RESET;
         knob_store_ff[1] <= KNOB_MID_RESET;
         knob_store_ff[2] <= '0;
         knob_store_ff[3] <= '0;
         knob_store_ff[4] <= '0;
         knob_store_ff[5] <= KNOB_FULL_RESET;
         arrival_y_ff     <= '0;
         level_follows_ff <= 1'b0;
         level_kept_ff    <= KNOB_FULL_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            last_pos_ff      <= last_pos_in;
            switch_wait_ff   <= switch_wait_in;
            down_count_ff    <= down_count_in;
            page_wait_ff     <= page_wait_in;
            pending_pg_ff    <= pending_pg_in;
            current_pg_ff    <= current_pg_in;
            freeze_latch_ff  <= freeze_latch_in;
            sealed_latch_ff  <= sealed_latch_in;
            prev_trigger_ff  <= req_gate_trigger;
            edge_count_ff    <= edge_count_in;
            knob_turn_ff     <= knob_turn_in;
            for (int i = 0; i < 6; i++) begin
               knob_store_ff[i] <= knob_store_in[i];
            end
            arrival_y_ff     <= arrival_y_in;
            level_follows_ff <= level_follows_in;
            level_kept_ff    <= level_kept_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_freeze_on      <= freeze_latch_in || req_gate_freeze;
         rsp_sealed_on      <= sealed_latch_in && !req_gate_freeze;
         rsp_page_now       <= current_pg_in;
         rsp_trigger_total  <= TOTAL_W'(edge_count_in);
         rsp_out_level      <= level_kept_in;
         rsp_speed_param    <= knob_store_in[0];
         rsp_density_param  <= knob_store_in[1];
         rsp_source_param   <= knob_store_in[2];
         rsp_quantise_param <= knob_store_in[3];
         rsp_width_param    <= knob_store_in[4];
      end
   end

endmodule

@@ rtl/core/pskq_checker.sv @@
// Port-level checker for the panel switch and knob qualifier, bound to the top level.
// Uses pskq_pkg for the trigger count width.
module pskq_checker
   import pskq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_freeze_on,
   input logic               rsp_sealed_on,
   input logic [TOTAL_W-1:0] rsp_trigger_total
);

   // Every accepted request shows its result on the next cycle.
   a_one_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   // Requests are held off only while a result waits on a stalled receiver.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting result");

   // Sealed freeze is only ever set together with the freeze latch.
   a_sealed_implies_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_sealed_on || rsp_freeze_on)
      else $error("sealed shown without freeze");

   // A waiting result holds its trigger count.
   a_hold_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_trigger_total))
      else $error("stalled trigger count changed");

endmodule

bind panel_switch_knob_qualifier_unit pskq_checker u_pskq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_freeze_on     (rsp_freeze_on),
   .rsp_sealed_on     (rsp_sealed_on),
   .rsp_trigger_total (rsp_trigger_total)
);
